// ===== hdl/hjlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjlp_pkg
// Shared types, constants and helpers of the linear-probe hash join engine.
// ----------------------------------------------------------------------------
package hjlp_pkg;

  localparam int TableDepth = 4096;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int MaxMatches = 63;
  localparam int CntW       = $clog2(MaxMatches + 1);

  localparam logic [31:0] CrcPoly  = 32'h82F6_3B78;
  localparam logic [31:0] CrcSeed  = 32'hFFFF_FFFF;
  localparam logic [31:0] EmptyKey = 32'h8000_0000;

  // request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_PROBE  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_MATCH = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_INSOK = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_CLR   = 3'd4;

  typedef struct packed {
    logic [1:0]       req;
    logic [31:0]      key;
    logic [31:0]      row;
    logic [AddrW-1:0] home;
  } q_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] row;
  } slot_t;

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} front_st_t;
  typedef enum logic [2:0] {B_IDLE, B_CLEAR, B_READ, B_EVAL, B_FIN} back_st_t;

  // eight reflected crc32c bit steps
  function automatic logic [31:0] crc_step8(input logic [31:0] c);
    logic [31:0] v;
    v = c;
    for (int b = 0; b < 8; b++) begin
      v = (v >> 1) ^ (v[0] ? CrcPoly : 32'd0);
    end
    return v;
  endfunction

  // log2 of slots in use, clamped to 1..AddrW
  function automatic logic [4:0] clamp_lg(input logic [3:0] lg);
    logic [4:0] v;
    v = {1'b0, lg};
    if (v < 5'd1) v = 5'd1;
    if (v > 5'(AddrW)) v = 5'(AddrW);
    return v;
  endfunction

endpackage

// ===== hdl/hjlp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjlp_front
// Takes request beats, hashes keys one crc byte per cycle, queues all but NONE.
// ----------------------------------------------------------------------------
module hjlp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req_type,
  input  logic signed [31:0]  in_join_key,
  input  logic [31:0]         in_row_index,
  input  logic                hold,
  output logic                push,
  output hjlp_pkg::q_item_t   push_item,
  input  logic                q_full
);

  hjlp_pkg::front_st_t st_r, st_nxt;
  logic [1:0]  req_r, req_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] row_r, row_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        acc;

  assign acc = in_valid && !in_stall;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      hjlp_pkg::F_IDLE: if (acc && in_req_type != hjlp_pkg::REQ_NONE) st_nxt = hjlp_pkg::F_HASH;
      hjlp_pkg::F_HASH: if (step_r == 2'd3) st_nxt = hjlp_pkg::F_PUSH;
      hjlp_pkg::F_PUSH: if (!q_full) st_nxt = hjlp_pkg::F_IDLE;
      default:          st_nxt = hjlp_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (st_r != hjlp_pkg::F_IDLE) || hold;
    push     = (st_r == hjlp_pkg::F_PUSH) && !q_full;
    req_nxt  = req_r;
    key_nxt  = key_r;
    row_nxt  = row_r;
    crc_nxt  = crc_r;
    step_nxt = step_r;
    case (st_r)
      hjlp_pkg::F_IDLE: begin
        req_nxt  = in_req_type;
        key_nxt  = $unsigned(in_join_key);
        row_nxt  = in_row_index;
        crc_nxt  = hjlp_pkg::CrcSeed ^ $unsigned(in_join_key);
        step_nxt = 2'd0;
      end
      hjlp_pkg::F_HASH: begin
        crc_nxt  = hjlp_pkg::crc_step8(crc_r);
        step_nxt = step_r + 2'd1;
      end
      default: ;
    endcase
    push_item.req  = req_r;
    push_item.key  = key_r;
    push_item.row  = row_r;
    push_item.home = crc_r[hjlp_pkg::AddrW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hjlp_pkg::F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    req_r  <= req_nxt;
    key_r  <= key_nxt;
    row_r  <= row_nxt;
    crc_r  <= crc_nxt;
    step_r <= step_nxt;
  end

endmodule

// ===== hdl/hjlp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjlp_queue
// Two-entry queue between the front and the table walker.
// ----------------------------------------------------------------------------
module hjlp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hjlp_pkg::q_item_t push_item,
  input  logic              pop,
  output hjlp_pkg::q_item_t pop_item,
  output logic              full,
  output logic              empty
);

  hjlp_pkg::q_item_t ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_item = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) ent_r[wp_r] <= push_item;
  end

endmodule

// ===== hdl/hjlp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjlp_back
// Table walker: clears, inserts and probes the slot memory, drives results.
// ----------------------------------------------------------------------------
module hjlp_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [4:0]                     lg,
  input  logic                           q_empty,
  input  hjlp_pkg::q_item_t              q_item,
  output logic                           pop,
  output logic                           init_busy,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_status,
  output logic [31:0]                    out_build_row,
  output logic [31:0]                    out_probe_row,
  output logic                           out_match_overflow,
  output logic                           out_last_result
);

  localparam int AW = hjlp_pkg::AddrW;

  hjlp_pkg::slot_t mem [hjlp_pkg::TableDepth];
  hjlp_pkg::slot_t rd_q;

  hjlp_pkg::back_st_t st_r, st_nxt;
  hjlp_pkg::q_item_t  cur_r, cur_nxt;
  logic [AW-1:0]               addr_r, addr_nxt;
  logic [AW:0]                 n_r, n_nxt;
  logic [hjlp_pkg::CntW-1:0]   cnt_r, cnt_nxt;
  logic                        ov_r, ov_nxt;
  logic                        clr_req_r, clr_req_nxt;
  logic [2:0]                  fin_r, fin_nxt;

  logic        ov_q_r, ov_q_nxt;
  logic        val_r, val_nxt;
  logic [2:0]  sta_r, sta_nxt;
  logic [31:0] brow_r, brow_nxt;
  logic [31:0] prow_r, prow_nxt;
  logic        last_r, last_nxt;

  logic [AW:0]   size;
  logic [AW-1:0] mask;
  logic          out_free, last_slot, hit;
  logic          we, re;
  logic [AW-1:0] wa;
  hjlp_pkg::slot_t wd;

  assign size      = (AW+1)'(1) << lg;
  assign mask      = AW'(size - (AW+1)'(1));
  assign out_free  = !val_r || !out_stall;
  assign last_slot = (n_r + (AW+1)'(1)) == size;
  assign hit       = rd_q.valid && (rd_q.key == cur_r.key) && (cur_r.key != hjlp_pkg::EmptyKey);
  assign init_busy = (st_r == hjlp_pkg::B_CLEAR) && !clr_req_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      hjlp_pkg::B_IDLE: begin
        if (!q_empty) begin
          case (q_item.req)
            hjlp_pkg::REQ_CLEAR:  st_nxt = hjlp_pkg::B_CLEAR;
            hjlp_pkg::REQ_INSERT: st_nxt = (q_item.key == hjlp_pkg::EmptyKey) ?
                                           hjlp_pkg::B_FIN : hjlp_pkg::B_READ;
            default:              st_nxt = hjlp_pkg::B_READ;
          endcase
        end
      end
      hjlp_pkg::B_CLEAR: begin
        if (addr_r == {AW{1'b1}}) st_nxt = clr_req_r ? hjlp_pkg::B_FIN : hjlp_pkg::B_IDLE;
      end
      hjlp_pkg::B_READ: st_nxt = hjlp_pkg::B_EVAL;
      hjlp_pkg::B_EVAL: begin
        if (cur_r.req == hjlp_pkg::REQ_INSERT) begin
          if (!rd_q.valid || last_slot) st_nxt = hjlp_pkg::B_FIN;
          else                          st_nxt = hjlp_pkg::B_READ;
        end else if (!rd_q.valid) begin
          st_nxt = hjlp_pkg::B_FIN;
        end else if (!(hit && cnt_r != hjlp_pkg::CntW'(hjlp_pkg::MaxMatches)) || out_free) begin
          st_nxt = last_slot ? hjlp_pkg::B_FIN : hjlp_pkg::B_READ;
        end
      end
      hjlp_pkg::B_FIN: if (out_free) st_nxt = hjlp_pkg::B_IDLE;
      default: st_nxt = hjlp_pkg::B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop         = (st_r == hjlp_pkg::B_IDLE) && !q_empty;
    cur_nxt     = cur_r;
    addr_nxt    = addr_r;
    n_nxt       = n_r;
    cnt_nxt     = cnt_r;
    ov_nxt      = ov_r;
    clr_req_nxt = clr_req_r;
    fin_nxt     = fin_r;
    we          = 1'b0;
    re          = 1'b0;
    wa          = addr_r;
    wd          = '0;
    val_nxt     = val_r && out_stall;
    sta_nxt     = sta_r;
    brow_nxt    = brow_r;
    prow_nxt    = prow_r;
    ov_q_nxt    = ov_q_r;
    last_nxt    = last_r;
    case (st_r)
      hjlp_pkg::B_IDLE: begin
        cur_nxt  = q_item;
        addr_nxt = q_item.home & mask;
        n_nxt    = '0;
        cnt_nxt  = '0;
        ov_nxt   = 1'b0;
        if (q_item.req == hjlp_pkg::REQ_CLEAR) begin
          addr_nxt    = '0;
          clr_req_nxt = 1'b1;
          fin_nxt     = hjlp_pkg::ST_CLR;
        end else begin
          fin_nxt = hjlp_pkg::ST_INSOK;
        end
      end
      hjlp_pkg::B_CLEAR: begin
        we       = 1'b1;
        addr_nxt = addr_r + AW'(1);
      end
      hjlp_pkg::B_READ: re = 1'b1;
      hjlp_pkg::B_EVAL: begin
        if (cur_r.req == hjlp_pkg::REQ_INSERT) begin
          if (!rd_q.valid) begin
            we       = 1'b1;
            wd.valid = 1'b1;
            wd.key   = cur_r.key;
            wd.row   = cur_r.row;
            fin_nxt  = hjlp_pkg::ST_INSOK;
          end else begin
            fin_nxt  = hjlp_pkg::ST_FULL;
            n_nxt    = n_r + (AW+1)'(1);
            addr_nxt = (addr_r + AW'(1)) & mask;
          end
        end else begin
          fin_nxt = hjlp_pkg::ST_DONE;
          if (rd_q.valid) begin
            if (hit && cnt_r != hjlp_pkg::CntW'(hjlp_pkg::MaxMatches)) begin
              if (out_free) begin
                val_nxt  = 1'b1;
                sta_nxt  = hjlp_pkg::ST_MATCH;
                brow_nxt = rd_q.row;
                prow_nxt = cur_r.row;
                ov_q_nxt = 1'b0;
                last_nxt = 1'b0;
                cnt_nxt  = cnt_r + hjlp_pkg::CntW'(1);
                n_nxt    = n_r + (AW+1)'(1);
                addr_nxt = (addr_r + AW'(1)) & mask;
              end
            end else begin
              if (hit) ov_nxt = 1'b1;
              n_nxt    = n_r + (AW+1)'(1);
              addr_nxt = (addr_r + AW'(1)) & mask;
            end
          end
        end
      end
      hjlp_pkg::B_FIN: begin
        if (out_free) begin
          val_nxt     = 1'b1;
          sta_nxt     = fin_r;
          brow_nxt    = '0;
          prow_nxt    = (fin_r == hjlp_pkg::ST_DONE) ? cur_r.row : 32'd0;
          ov_q_nxt    = (fin_r == hjlp_pkg::ST_DONE) && ov_r;
          last_nxt    = 1'b1;
          clr_req_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= hjlp_pkg::B_CLEAR;
      addr_r    <= '0;
      clr_req_r <= 1'b0;
      val_r     <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      addr_r    <= addr_nxt;
      clr_req_r <= clr_req_nxt;
      val_r     <= val_nxt;
    end
    cur_r  <= cur_nxt;
    n_r    <= n_nxt;
    cnt_r  <= cnt_nxt;
    ov_r   <= ov_nxt;
    fin_r  <= fin_nxt;
    sta_r  <= sta_nxt;
    brow_r <= brow_nxt;
    prow_r <= prow_nxt;
    ov_q_r <= ov_q_nxt;
    last_r <= last_nxt;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[addr_r];
  end

  assign out_valid          = val_r;
  assign out_status         = sta_r;
  assign out_build_row      = brow_r;
  assign out_probe_row      = prow_r;
  assign out_match_overflow = ov_q_r;
  assign out_last_result    = last_r;

endmodule

// ===== hdl/hash_join_linear_probe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_join_linear_probe
// Open-addressing hash join with crc32c home slots and linear probing.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// in_      in   in_valid/in_stall  req_type, join_key, row_index
// out_     out  out_valid/out_stall status, build_row, probe_row,
//                                  match_overflow, last_result
// cfg_     in   cfg_wr_en          cfg_wr_data (table_size_log2)
//
// the front hashes a key 8 crc bits per cycle and queues it.
// the walker takes one item at a time, reading each visited slot (B_READ)
// and then checking it (B_EVAL); a clear sweeps all 4096 slots.
// after reset the same sweep of all 4096 slots runs with in_stall held high.
// out_stall holds the result register; a walk with a result to give waits.
// ----------------------------------------------------------------------------
module hash_join_linear_probe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_join_key,
  input  logic [31:0]        in_row_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [31:0]        out_build_row,
  output logic [31:0]        out_probe_row,
  output logic               out_match_overflow,
  output logic               out_last_result,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data
);

  logic [3:0]        size_lg_r, size_lg_nxt;
  logic              push, pop, q_full, q_empty, init_busy;
  hjlp_pkg::q_item_t push_item, pop_item;

  assign size_lg_nxt = cfg_wr_en ? cfg_wr_data : size_lg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_lg_r <= 4'd12;
    end else begin
      size_lg_r <= size_lg_nxt;
    end
  end

  hjlp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_join_key  (in_join_key),
    .in_row_index (in_row_index),
    .hold         (init_busy),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  hjlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  hjlp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .lg                 (hjlp_pkg::clamp_lg(size_lg_r)),
    .q_empty            (q_empty),
    .q_item             (pop_item),
    .pop                (pop),
    .init_busy          (init_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_build_row      (out_build_row),
    .out_probe_row      (out_probe_row),
    .out_match_overflow (out_match_overflow),
    .out_last_result    (out_last_result)
  );

endmodule
